// File: hw/rtl/dkdl_pkg.sv
// Shared types and codes for the depth-keyed display list.
// No dependencies; imported by every module of the block except dkdl_ram.
package dkdl_pkg;

  localparam int DEPTH_W = 16;
  localparam int CHAR_W  = 16;
  localparam int MAT_W   = 32;
  localparam int NAME_W  = 16;

  // record kinds
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_REMOVE  = 2'd1;
  localparam logic [1:0] OP_PLACE   = 2'd2;
  localparam logic [1:0] OP_READOUT = 2'd3;

  typedef logic [DEPTH_W-1:0] depth_t;

  // one stored placement, as held in the slot RAM
  typedef struct packed {
    depth_t              depth;
    logic [CHAR_W-1:0]   character;
    logic                has_char;
    logic                has_mat;
    logic [MAT_W-1:0]    matrix;
    logic [NAME_W-1:0]   name;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // results of the shared depth comparator
  typedef struct packed {
    logic eq;     // candidate equals the search key
    logic above;  // candidate above the last depth sent
    logic below;  // candidate below the best depth found so far
  } cmp_res_t;

endpackage

// File: hw/rtl/dkdl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dkdl_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/dkdl_cmp.sv
// Shared depth comparator used by both the key search and the ordered readout.
// Depends on dkdl_pkg.
module dkdl_cmp (
  input  dkdl_pkg::depth_t   cand,
  input  dkdl_pkg::depth_t   key,
  input  dkdl_pkg::depth_t   floor_d,
  input  dkdl_pkg::depth_t   best_d,
  output dkdl_pkg::cmp_res_t res
);

  import dkdl_pkg::*;

  always_comb begin
    res.eq    = (cand == key);
    res.above = (cand > floor_d);
    res.below = (cand < best_d);
  end

endmodule

// File: hw/rtl/depth_keyed_display_list.sv
// Top level of the depth-keyed display list: sequencer, slot RAM and result register.
// Depends on dkdl_pkg, dkdl_ram and dkdl_cmp.
//
//  Channel  Direction  Handshake              Payload
//  -------  ---------  ---------------------  ---------------------------------------------
//  in       sink       in_valid / in_stall    operation, depth, is_move, char_present,
//                                             char_code, matrix_present, matrix_ref, name_ref
//  out      source     out_valid / out_stall  entry_*, last, empty_res, overflow
//
// Operation: a clear is done when it is accepted. A remove or place scans the slot RAM one
// entry a cycle, then a remove shifts the tail down one entry a cycle and a place writes
// the entry in S_PUT unless the list overflows. A readout is a selection sort over the RAM
// read port: each result takes a full scan of the list and then waits in the output
// register for its transfer. Reset clears the list count, the overflow flag and the
// sequencer; RAM contents are left as they are. in_stall is high whenever a record is in
// progress, and a stalled result holds the sequencer until the transfer completes.
module depth_keyed_display_list #(
  parameter int ENTRIES = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  operation,
  input  dkdl_pkg::depth_t            depth,
  input  logic                        is_move,
  input  logic                        char_present,
  input  logic [dkdl_pkg::CHAR_W-1:0] char_code,
  input  logic                        matrix_present,
  input  logic [dkdl_pkg::MAT_W-1:0]  matrix_ref,
  input  logic [dkdl_pkg::NAME_W-1:0] name_ref,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output dkdl_pkg::depth_t            entry_depth,
  output logic [dkdl_pkg::CHAR_W-1:0] entry_character,
  output logic                        entry_has_character,
  output logic                        entry_has_matrix,
  output logic [dkdl_pkg::MAT_W-1:0]  entry_matrix,
  output logic [dkdl_pkg::NAME_W-1:0] entry_name,
  output logic                        last,
  output logic                        empty_res,
  output logic                        overflow
);

  import dkdl_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;  // search for the record's depth
  localparam logic [2:0] S_SHIFT = 3'd2;  // close the gap after a remove
  localparam logic [2:0] S_PUT   = 3'd3;  // write a new or updated entry
  localparam logic [2:0] S_RSCAN = 3'd4;  // find the next depth in order
  localparam logic [2:0] S_ROUT  = 3'd5;  // result waiting for its transfer

  logic [2:0]  state;
  logic [CW-1:0] count;
  logic        ovf;

  // held record
  logic [1:0]        req_op;
  depth_t            req_depth;
  logic              req_move;
  logic              req_hc;
  logic [CHAR_W-1:0] req_char;
  logic              req_hm;
  logic [MAT_W-1:0]  req_mat;
  logic [NAME_W-1:0] req_name;

  // scan control
  logic [CW-1:0] idx;       // next RAM address to issue
  logic          rd_valid;  // RAM data valid this cycle
  logic [CW-1:0] rd_idx;    // address the RAM data came from
  logic          found;
  logic [CW-1:0] found_idx;
  slot_t         found_rec;

  // readout selection
  logic          first;     // no result sent yet in this readout
  logic          have;      // best holds a candidate
  slot_t         best;
  depth_t        prev_depth;
  logic [CW-1:0] sent;

  // RAM ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  slot_t             ram_wdata;
  logic [SLOT_W-1:0] ram_rdata;
  slot_t             rd_rec;
  logic              issue;
  logic              scan_done;
  cmp_res_t          cmp;
  slot_t             fresh_rec;
  slot_t             merged_rec;
  logic [CW-1:0]     shift_dst;
  logic              in_xfer;
  logic              out_xfer;

  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign rd_rec    = slot_t'(ram_rdata);
  assign issue     = ((state == S_SCAN) || (state == S_SHIFT) || (state == S_RSCAN))
                     && (idx < count);
  assign scan_done = (idx == count) && !rd_valid;
  assign shift_dst = rd_idx - CW'(1);

  dkdl_ram #(
    .WIDTH  (SLOT_W),
    .DEPTH  (ENTRIES),
    .ADDR_W (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  dkdl_cmp u_cmp (
    .cand    (rd_rec.depth),
    .key     (req_depth),
    .floor_d (prev_depth),
    .best_d  (best.depth),
    .res     (cmp)
  );

  // entry built from the record alone: absent character or matrix stores zero
  always_comb begin
    fresh_rec.depth     = req_depth;
    fresh_rec.character = req_hc ? req_char : '0;
    fresh_rec.has_char  = req_hc;
    fresh_rec.has_mat   = req_hm;
    fresh_rec.matrix    = req_hm ? req_mat : '0;
    fresh_rec.name      = req_name;
  end

  // partial update of an existing entry; has-character flag is left alone
  always_comb begin
    merged_rec = found_rec;
    if (req_hc) begin
      merged_rec.character = req_char;
    end
    if (req_hm) begin
      merged_rec.matrix  = req_mat;
      merged_rec.has_mat = 1'b1;
    end
    if (req_name != '0) begin
      merged_rec.name = req_name;
    end
  end

  // RAM write side
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = fresh_rec;
    if ((state == S_SHIFT) && rd_valid) begin
      ram_we    = 1'b1;
      ram_waddr = shift_dst[AW-1:0];
      ram_wdata = rd_rec;
    end else if (state == S_PUT) begin
      ram_we = 1'b1;
      if (found) begin
        ram_waddr = found_idx[AW-1:0];
        ram_wdata = (!req_move && req_hc) ? fresh_rec : merged_rec;
      end
    end
  end

  // held record: payload only, loaded on an accepted transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_op    <= operation;
      req_depth <= depth;
      req_move  <= is_move;
      req_hc    <= char_present;
      req_char  <= char_code;
      req_hm    <= matrix_present;
      req_mat   <= matrix_ref;
      req_name  <= name_ref;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
      found     <= 1'b0;
      first     <= 1'b0;
      have      <= 1'b0;
      sent      <= '0;
    end else begin
      rd_valid <= issue;
      rd_idx   <= idx;
      if (issue) begin
        idx <= idx + CW'(1);
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            idx   <= '0;
            found <= 1'b0;
            case (operation)
              OP_CLEAR: begin
                count <= '0;
                ovf   <= 1'b0;
              end
              OP_REMOVE, OP_PLACE: begin
                state <= S_SCAN;
              end
              default: begin
                // readout
                sent  <= '0;
                first <= 1'b1;
                have  <= 1'b0;
                if (count == '0) begin
                  entry_depth         <= '0;
                  entry_character     <= '0;
                  entry_has_character <= 1'b0;
                  entry_has_matrix    <= 1'b0;
                  entry_matrix        <= '0;
                  entry_name          <= '0;
                  last                <= 1'b1;
                  empty_res           <= 1'b1;
                  overflow            <= ovf;
                  out_valid           <= 1'b1;
                  state               <= S_ROUT;
                end else begin
                  state <= S_RSCAN;
                end
              end
            endcase
          end
        end

        S_SCAN: begin
          if (rd_valid && cmp.eq) begin
            found     <= 1'b1;
            found_idx <= rd_idx;
            found_rec <= rd_rec;
          end
          if (scan_done) begin
            if (req_op == OP_REMOVE) begin
              if (found) begin
                idx   <= found_idx + CW'(1);
                state <= S_SHIFT;
              end else begin
                state <= S_IDLE;
              end
            end else if (found || (count < FULL)) begin
              state <= S_PUT;
            end else begin
              ovf   <= 1'b1;
              state <= S_IDLE;
            end
          end
        end

        S_SHIFT: begin
          if (scan_done) begin
            count <= count - CW'(1);
            state <= S_IDLE;
          end
        end

        S_PUT: begin
          if (!found) begin
            count <= count + CW'(1);
          end
          state <= S_IDLE;
        end

        S_RSCAN: begin
          if (rd_valid && (first || cmp.above) && (!have || cmp.below)) begin
            have <= 1'b1;
            best <= rd_rec;
          end
          if (scan_done) begin
            entry_depth         <= best.depth;
            entry_character     <= best.character;
            entry_has_character <= best.has_char;
            entry_has_matrix    <= best.has_mat;
            entry_matrix        <= best.matrix;
            entry_name          <= best.name;
            last                <= ((sent + CW'(1)) == count);
            empty_res           <= 1'b0;
            overflow            <= ovf;
            out_valid           <= 1'b1;
            state               <= S_ROUT;
          end
        end

        S_ROUT: begin
          if (out_xfer) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= S_IDLE;
            end else begin
              sent       <= sent + CW'(1);
              prev_depth <= best.depth;
              first      <= 1'b0;
              have       <= 1'b0;
              idx        <= '0;
              state      <= S_RSCAN;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for depth_keyed_display_list: a mirror of the display list
// predicts every readout transfer, which is then checked field by field.
// Depends on dkdl_pkg and the RTL of the block; nothing else.
module tb;
  import dkdl_pkg::*;

  localparam int LIST_SLOTS   = 32;         // ENTRIES as built
  localparam int RANDOM_ITEMS = 160;
  localparam int POOL_SIZE    = 48;         // more keys than slots, so the list overflows
  localparam int HOLD_CYCLES  = 400;        // long receiver hold-off
  localparam int DRAIN_CYCLES = 200;        // > slowest remove or place at a full list
  // worst run: ~200 records, each a full readout (a selection sort of the list, 32 stalled
  // transfers, sender gap); the limit leaves a wide margin above that
  localparam int CYCLE_LIMIT  = 1_500_000;

  typedef struct packed {
    logic [1:0]        operation;
    depth_t            depth;
    logic              is_move;
    logic              char_present;
    logic [CHAR_W-1:0] char_code;
    logic              matrix_present;
    logic [MAT_W-1:0]  matrix_ref;
    logic [NAME_W-1:0] name_ref;
  } display_record_t;

  // one readout transfer; field order matches the port order used by the monitor
  typedef struct packed {
    slot_t entry;
    logic  last;
    logic  empty;
    logic  ovf;
  } listed_entry_t;

  // Mirror of the display list. apply_record takes each accepted record and queues the
  // entries a readout must give; match_entry checks one result transfer against them.
  class display_list_mirror;
    slot_t         slots[LIST_SLOTS];
    int unsigned   count;
    bit            ovf;
    listed_entry_t due_entries[$];
    int unsigned   errors;
    int unsigned   seen;

    function new();
      count  = 0;
      ovf    = 1'b0;
      errors = 0;
      seen   = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function int unsigned locate(depth_t d);
      for (int unsigned i = 0; i < count && i < LIST_SLOTS; i++)
        if (slots[i].depth == d) return i;
      return LIST_SLOTS;
    endfunction

    // a new or replaced entry keeps only what the record carries
    function slot_t fresh_slot(display_record_t r);
      slot_t s;
      s.depth     = r.depth;
      s.character = r.char_present ? r.char_code : '0;
      s.has_char  = r.char_present;
      s.has_mat   = r.matrix_present;
      s.matrix    = r.matrix_present ? r.matrix_ref : '0;
      s.name      = r.name_ref;
      return s;
    endfunction

    function void apply_record(display_record_t r);
      int unsigned   at;
      int unsigned   key;
      int unsigned   j;
      int unsigned   order[LIST_SLOTS];
      listed_entry_t e;
      at = locate(r.depth);
      case (r.operation)
        OP_CLEAR: begin
          count = 0;
          ovf   = 1'b0;
        end
        OP_REMOVE: begin
          if (at < LIST_SLOTS) begin
            for (int unsigned i = at; i + 1 < count; i++) slots[i] = slots[i + 1];
            count--;
          end
        end
        OP_PLACE: begin
          if (at >= LIST_SLOTS) begin
            if (count >= LIST_SLOTS) begin
              ovf = 1'b1;
            end else begin
              slots[count] = fresh_slot(r);
              count++;
            end
          end else if (!r.is_move && r.char_present) begin
            slots[at] = fresh_slot(r);
          end else begin
            // partial update: has-character flag stays as it was
            if (r.char_present) slots[at].character = r.char_code;
            if (r.matrix_present) begin
              slots[at].matrix  = r.matrix_ref;
              slots[at].has_mat = 1'b1;
            end
            if (r.name_ref != '0) slots[at].name = r.name_ref;
          end
        end
        default: begin
          e     = '0;
          e.ovf = ovf;
          if (count == 0) begin
            e.last      = 1'b1;
            e.empty     = 1'b1;
            due_entries = {due_entries, e};
          end else begin
            for (int unsigned i = 0; i < count; i++) order[i] = i;
            for (int unsigned i = 1; i < count; i++) begin
              key = order[i];
              j   = i;
              while (j > 0 && slots[order[j - 1]].depth > slots[key].depth) begin
                order[j] = order[j - 1];
                j--;
              end
              order[j] = key;
            end
            for (int unsigned i = 0; i < count; i++) begin
              e.entry     = slots[order[i]];
              e.last      = (i + 1 == count);
              due_entries = {due_entries, e};
            end
          end
        end
      endcase
    endfunction

    task compare_field(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %h, expected %h", seen, field, got, want));
    endtask

    task match_entry(listed_entry_t got);
      listed_entry_t want;
      seen++;
      if (due_entries.size() == 0) begin
        report($sformatf("result %0d (depth %h) with nothing expected", seen, got.entry.depth));
        return;
      end
      want = due_entries.pop_front();
      compare_field("entry_depth", 32'(got.entry.depth), 32'(want.entry.depth));
      compare_field("entry_character", 32'(got.entry.character), 32'(want.entry.character));
      compare_field("entry_has_character", 32'(got.entry.has_char), 32'(want.entry.has_char));
      compare_field("entry_has_matrix", 32'(got.entry.has_mat), 32'(want.entry.has_mat));
      compare_field("entry_matrix", got.entry.matrix, want.entry.matrix);
      compare_field("entry_name", 32'(got.entry.name), 32'(want.entry.name));
      compare_field("last", 32'(got.last), 32'(want.last));
      compare_field("empty_res", 32'(got.empty), 32'(want.empty));
      compare_field("overflow", 32'(got.ovf), 32'(want.ovf));
    endtask
  endclass

  // every block input is known from time zero
  logic              clk            = 1'b0;
  logic              rst            = 1'b1;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [1:0]        operation      = OP_CLEAR;
  depth_t            depth          = '0;
  logic              is_move        = 1'b0;
  logic              char_present   = 1'b0;
  logic [CHAR_W-1:0] char_code      = '0;
  logic              matrix_present = 1'b0;
  logic [MAT_W-1:0]  matrix_ref     = '0;
  logic [NAME_W-1:0] name_ref       = '0;

  logic              out_valid;
  logic              out_stall;
  depth_t            entry_depth;
  logic [CHAR_W-1:0] entry_character;
  logic              entry_has_character;
  logic              entry_has_matrix;
  logic [MAT_W-1:0]  entry_matrix;
  logic [NAME_W-1:0] entry_name;
  logic              last;
  logic              empty_res;
  logic              overflow;

  // receiver stall: per-transfer draw, plus the one long hold-off from its own process
  logic draw_stall = 1'b0;
  logic hold_off   = 1'b0;
  assign out_stall = draw_stall | hold_off;

  display_list_mirror mirror = new();

  depth_t      depth_pool[POOL_SIZE];
  bit          send_gaps    = 1'b1;
  bit          recv_gaps    = 1'b1;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned cycles       = 0;

  depth_keyed_display_list #(.ENTRIES(LIST_SLOTS)) dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .operation           (operation),
    .depth               (depth),
    .is_move             (is_move),
    .char_present        (char_present),
    .char_code           (char_code),
    .matrix_present      (matrix_present),
    .matrix_ref          (matrix_ref),
    .name_ref            (name_ref),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .entry_depth         (entry_depth),
    .entry_character     (entry_character),
    .entry_has_character (entry_has_character),
    .entry_has_matrix    (entry_has_matrix),
    .entry_matrix        (entry_matrix),
    .entry_name          (entry_name),
    .last                (last),
    .empty_res           (empty_res),
    .overflow            (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic display_record_t make_record(logic [1:0] op, depth_t d, logic mv,
      logic hc, logic [CHAR_W-1:0] cid, logic hm, logic [MAT_W-1:0] mat,
      logic [NAME_W-1:0] nm);
    display_record_t r;
    r.operation      = op;
    r.depth          = d;
    r.is_move        = mv;
    r.char_present   = hc;
    r.char_code      = cid;
    r.matrix_present = hm;
    r.matrix_ref     = mat;
    r.name_ref       = nm;
    return r;
  endfunction

  // random content around a chosen record kind and key; a quarter of names are "none"
  function automatic display_record_t random_record(logic [1:0] op, depth_t d);
    logic [NAME_W-1:0] nm;
    nm = ($urandom_range(0, 3) == 0) ? '0 : NAME_W'($urandom);
    return make_record(op, d, 1'($urandom), 1'($urandom), CHAR_W'($urandom), 1'($urandom),
                       MAT_W'($urandom), nm);
  endfunction

  // mostly keys from the pool so places and removes hit live entries
  function automatic depth_t pick_depth();
    if ($urandom_range(0, 9) == 0) return depth_t'($urandom);
    return depth_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Offer one record after a random gap; valid stays up between back-to-back records.
  // The transfer happens at the edge where in_stall is seen low.
  task automatic send_record(display_record_t r);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    operation      <= r.operation;
    depth          <= r.depth;
    is_move        <= r.is_move;
    char_present   <= r.char_present;
    char_code      <= r.char_code;
    matrix_present <= r.matrix_present;
    matrix_ref     <= r.matrix_ref;
    name_ref       <= r.name_ref;
    do @(posedge clk); while (in_stall);
    mirror.apply_record(r);
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (mirror.due_entries.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned chunk;
    int unsigned burst;
    int unsigned base;
    depth_pool[0] = '0;
    depth_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) depth_pool[i] = depth_t'($urandom);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, extreme fields, replace versus partial update
    send_record(make_record(OP_READOUT, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 32'h0, 16'h0000));
    send_record(make_record(OP_PLACE, 16'h0000, 1'b0, 1'b1, 16'hFFFF, 1'b1, 32'hFFFFFFFF,
                            16'hFFFF));
    // carried values without their flags must be stored as zero
    send_record(make_record(OP_PLACE, 16'hFFFF, 1'b0, 1'b0, 16'h1234, 1'b0, 32'hDEADBEEF,
                            16'h0000));
    send_record(make_record(OP_PLACE, 16'h8000, 1'b0, 1'b1, 16'h0000, 1'b1, 32'h0, 16'h0001));
    send_record(make_record(OP_READOUT, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 1'b1, 32'hFFFFFFFF,
                            16'hFFFF));
    // non-move with a character: whole entry replaced
    send_record(make_record(OP_PLACE, 16'hFFFF, 1'b0, 1'b1, 16'h0A5A, 1'b0, 32'h13579BDF,
                            16'h0222));
    // move with a character: character only, flag and name kept
    send_record(make_record(OP_PLACE, 16'h0000, 1'b1, 1'b1, 16'h1111, 1'b0, 32'h0, 16'h0000));
    // place without a character on a live depth: matrix update sets its flag
    send_record(make_record(OP_PLACE, 16'h8000, 1'b0, 1'b0, 16'h2222, 1'b1, 32'h12345678,
                            16'h0000));
    send_record(make_record(OP_PLACE, 16'hFFFF, 1'b1, 1'b1, 16'h3333, 1'b1, 32'h0F0F0F0F,
                            16'h4444));
    // move carrying nothing: no change
    send_record(make_record(OP_PLACE, 16'h8000, 1'b1, 1'b0, 16'h5555, 1'b0, 32'hFFFFFFFF,
                            16'h0000));
    send_record(make_record(OP_READOUT, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 32'h0, 16'h0000));
    // remove of an absent depth, then of the lowest one
    send_record(make_record(OP_REMOVE, 16'h1234, 1'b0, 1'b0, 16'h0000, 1'b0, 32'h0, 16'h0000));
    send_record(make_record(OP_REMOVE, 16'h0000, 1'b1, 1'b1, 16'hFFFF, 1'b1, 32'hFFFFFFFF,
                            16'hFFFF));
    send_record(make_record(OP_READOUT, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 32'h0, 16'h0000));
    send_record(make_record(OP_REMOVE, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0, 32'h0, 16'h0000));
    send_record(make_record(OP_REMOVE, 16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0, 32'h0, 16'h0000));
    send_record(make_record(OP_READOUT, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 32'h0, 16'h0000));
    // a move onto a new depth still appends
    send_record(make_record(OP_PLACE, 16'h0007, 1'b1, 1'b0, 16'h0000, 1'b1, 32'hA5A5A5A5,
                            16'h0000));
    send_record(make_record(OP_CLEAR, 16'h0007, 1'b1, 1'b1, 16'hFFFF, 1'b1, 32'hFFFFFFFF,
                            16'hFFFF));
    send_record(make_record(OP_READOUT, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 32'h0, 16'h0000));
    send_record(make_record(OP_PLACE, 16'h0007, 1'b0, 1'b1, 16'h0042, 1'b0, 32'h0, 16'h7777));

    // random: bursts of places and removes closed by a readout, some clears and noise
    base  = items_sent;
    chunk = 0;
    while (items_sent < base + RANDOM_ITEMS) begin
      send_gaps = ($urandom_range(0, 3) != 0);
      if (chunk == 5) wait_for_results();   // sender pause until every due result has been seen
      if (chunk == 0) begin
        // the whole pool: fills the list, the surplus overflows
        for (int i = 0; i < POOL_SIZE; i++) send_record(random_record(OP_PLACE, depth_pool[i]));
        send_record(random_record(OP_READOUT, pick_depth()));
      end else if ($urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 4);
        repeat (burst) send_record(random_record(2'($urandom), depth_t'($urandom)));
      end else begin
        if ($urandom_range(0, 6) == 0) send_record(random_record(OP_CLEAR, pick_depth()));
        burst = $urandom_range(2, 10);
        repeat (burst) begin
          if ($urandom_range(0, 9) < 7) send_record(random_record(OP_PLACE, pick_depth()));
          else send_record(random_record(OP_REMOVE, pick_depth()));
        end
        send_record(random_record(OP_READOUT, pick_depth()));
      end
      chunk++;
    end

    wait_for_results();
    // a late place or remove may still be busy; any stray transfer is caught here
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("[depth_keyed_display_list] OK");
    end else begin
      $display("[depth_keyed_display_list] ERROR");
    end
    $finish;
  end

  // receiver: per transfer a random stall from now, switching to stall-free stretches at
  // random; the wait ends on the edge that completes the transfer
  initial begin : result_sink
    int unsigned hold;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) recv_gaps = !recv_gaps;
      hold = recv_gaps ? $urandom_range(0, 14) : 0;
      if (hold != 0) begin
        draw_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      draw_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // long hold-off mid-readout of the full list; the sender keeps offering meanwhile
  initial begin : long_hold
    while (rst) @(posedge clk);
    while (results_seen < 24) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin : result_monitor
    listed_entry_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {entry_depth, entry_character, entry_has_character, entry_has_matrix,
             entry_matrix, entry_name, last, empty_res, overflow};
      mirror.match_entry(got);
      results_seen <= results_seen + 1;
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[depth_keyed_display_list] ERROR");
    $finish;
  end

endmodule
